// File: rtl/pulse_width_change_gate_assert.svh
// assertion macros for the pulse width change gate checker
// needs nothing but a clock and an active-low reset at the place of use
`ifndef PULSE_WIDTH_CHANGE_GATE_ASSERT_SVH
`define PULSE_WIDTH_CHANGE_GATE_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define PWCG_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("pwcg assertion failed");

// next-cycle implication, off while reset is asserted
`define PWCG_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("pwcg assertion failed");

`endif

// File: rtl/pwcg_pkg.sv
// shared constants and types for the pulse width change gate
// no dependencies
package pwcg_pkg;

	localparam int NUM_PORTS  = 5;
	localparam int WINDOW_LEN = 5;

	localparam int PORT_W   = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int PTR_W    = $clog2(WINDOW_LEN);
	localparam int SAMPLE_W = 12;
	localparam int CFG_W    = 16;
	localparam int IDX_W    = 3;

	// register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_MIN_INTERVAL = 3'd0;
	localparam logic [IDX_W-1:0] REG_CHANGE_THR   = 3'd1;
	localparam logic [IDX_W-1:0] REG_SETTLE_RANGE = 3'd2;
	localparam logic [IDX_W-1:0] REG_PULSE_MIN    = 3'd3;
	localparam logic [IDX_W-1:0] REG_PULSE_MAX    = 3'd4;
	localparam logic [IDX_W-1:0] REG_PORT_ENABLE  = 3'd5;

	typedef struct packed {
		logic [15:0]         min_interval_ms;
		logic [SAMPLE_W-1:0] change_threshold;
		logic [SAMPLE_W-1:0] settle_range;
		logic [SAMPLE_W-1:0] pulse_min;
		logic [SAMPLE_W-1:0] pulse_max;
		logic [4:0]          port_enable_mask;
	} cfg_t;

endpackage

// File: rtl/pwcg_cfg.sv
// configuration register file of the pulse width change gate
// depends on pwcg_pkg
module pwcg_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [pwcg_pkg::IDX_W-1:0] cfg_index,
	input  logic [pwcg_pkg::CFG_W-1:0] cfg_data,
	output pwcg_pkg::cfg_t            cfg
);
	import pwcg_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_interval_ms  <= 16'd15;
			cfg_q.change_threshold <= 12'd6;
			cfg_q.settle_range     <= 12'd6;
			cfg_q.pulse_min        <= 12'd500;
			cfg_q.pulse_max        <= 12'd2500;
			cfg_q.port_enable_mask <= 5'd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MIN_INTERVAL: cfg_q.min_interval_ms  <= cfg_data;
				REG_CHANGE_THR:   cfg_q.change_threshold <= cfg_data[SAMPLE_W-1:0];
				REG_SETTLE_RANGE: cfg_q.settle_range     <= cfg_data[SAMPLE_W-1:0];
				REG_PULSE_MIN:    cfg_q.pulse_min        <= cfg_data[SAMPLE_W-1:0];
				REG_PULSE_MAX:    cfg_q.pulse_max        <= cfg_data[SAMPLE_W-1:0];
				REG_PORT_ENABLE:  cfg_q.port_enable_mask <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/pwcg_window.sv
// per-port sample windows with settle detection over the updated window
// depends on pwcg_pkg
module pwcg_window (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [pwcg_pkg::PORT_W-1:0]   port,
	input  logic [pwcg_pkg::SAMPLE_W-1:0] sample,
	input  logic                         push,
	input  logic [pwcg_pkg::SAMPLE_W-1:0] settle_range,
	output logic                         settled
);
	import pwcg_pkg::*;

	logic [SAMPLE_W-1:0] samples_q [NUM_PORTS][WINDOW_LEN];
	logic [PTR_W-1:0]    ptr_q     [NUM_PORTS];

	logic [PTR_W-1:0]    ptr;
	logic [PTR_W-1:0]    ptr_next;
	logic [SAMPLE_W-1:0] row [WINDOW_LEN];
	logic [SAMPLE_W-1:0] lo;
	logic [SAMPLE_W-1:0] hi;

	always_comb begin
		ptr = ptr_q[port];
		if (32'(ptr) >= WINDOW_LEN) ptr = '0;
		ptr_next = (32'(ptr) == WINDOW_LEN - 1) ? '0 : ptr + 1'b1;
		// row as it stands after the new sample is written
		for (int i = 0; i < WINDOW_LEN; i++) begin
			row[i] = (32'(ptr) == i) ? sample : samples_q[port][i];
		end
		lo = row[0];
		hi = row[0];
		for (int i = 1; i < WINDOW_LEN; i++) begin
			if (row[i] < lo) lo = row[i];
			if (row[i] > hi) hi = row[i];
		end
		settled = (hi - lo) <= settle_range;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PORTS; p++) begin
				ptr_q[p] <= '0;
				for (int i = 0; i < WINDOW_LEN; i++) samples_q[p][i] <= '0;
			end
		end else if (push) begin
			samples_q[port][ptr] <= sample;
			ptr_q[port]          <= ptr_next;
		end
	end

endmodule

// File: rtl/pulse_width_change_gate.sv
// pulse width change gate top level: input register, per-port decision, result register
// depends on pwcg_pkg, pwcg_cfg and pwcg_window
//
// channel  | valid / stall        | payload
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_stall  | port_index, pulse_width, now_ms
// out      | out_valid / out_stall| send, sent_width, sent_port, settle_send
// cfg      | cfg_write            | cfg_index, cfg_data
//
// one request per cycle sustained unless out_stall holds the result register; a request
// goes into the input register, then its result into the result register
// the per-port read-modify-write of the decision state sits in the logic
// between the input register and the result register
// arst_n clears all per-port state, windows and valid flags; config returns to defaults
// out_stall holds the result register; in_stall rises only when the input
// register is full and cannot move on
module pulse_width_change_gate (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [2:0]                 port_index,
	input  logic [15:0]                pulse_width,
	input  logic [31:0]                now_ms,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       send,
	output logic [11:0]                sent_width,
	output logic [2:0]                 sent_port,
	output logic                       settle_send,
	input  logic                       cfg_write,
	input  logic [pwcg_pkg::IDX_W-1:0] cfg_index,
	input  logic [pwcg_pkg::CFG_W-1:0] cfg_data
);
	import pwcg_pkg::*;

	cfg_t cfg;

	pwcg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	logic        valid_s1;
	logic [2:0]  port_index_s1;
	logic [15:0] pulse_width_s1;
	logic [31:0] now_ms_s1;

	// result register
	logic                valid_s2;
	logic                send_s2;
	logic [SAMPLE_W-1:0] sent_width_s2;
	logic [2:0]          sent_port_s2;
	logic                settle_s2;

	// per-port decision state
	logic [SAMPLE_W-1:0] last_width_q [NUM_PORTS];
	logic [31:0]         last_time_q  [NUM_PORTS];
	logic                settled_q    [NUM_PORTS];

	logic advance;
	logic fire;

	// s1 moves on when the result register is empty or being taken
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign fire     = valid_s1 && advance;

	// decision logic
	logic                in_range;
	logic [PORT_W-1:0]   sel;
	logic [7:0]          mask_ext;
	logic                port_ok;
	logic                width_ok;
	logic [31:0]         elapsed;
	logic                time_ok;
	logic                accept;
	logic [SAMPLE_W-1:0] w;
	logic [SAMPLE_W-1:0] prev;
	logic                first;
	logic [SAMPLE_W-1:0] change;
	logic                big_change;
	logic                win_settled;
	logic                settle_go;
	logic                send_d;
	logic                settle_d;
	logic                push;

	always_comb begin
		in_range   = 32'(port_index_s1) < NUM_PORTS;
		// out-of-range ports park on entry zero; they never pass port_ok
		sel        = in_range ? PORT_W'(port_index_s1) : '0;
		mask_ext   = 8'(cfg.port_enable_mask);
		port_ok    = in_range && mask_ext[port_index_s1];
		width_ok   = (pulse_width_s1 >= 16'(cfg.pulse_min)) &&
		             (pulse_width_s1 <= 16'(cfg.pulse_max));
		// wrapping time difference since the last send
		elapsed    = now_ms_s1 - last_time_q[sel];
		time_ok    = elapsed >= 32'(cfg.min_interval_ms);
		accept     = port_ok && width_ok && time_ok;
		w          = pulse_width_s1[SAMPLE_W-1:0];
		prev       = last_width_q[sel];
		// zero width means nothing sent yet on this port
		first      = prev == '0;
		change     = (w > prev) ? (w - prev) : (prev - w);
		big_change = change >= cfg.change_threshold;
		settle_go  = win_settled && !settled_q[sel] && (change != '0);
		// the window takes every accepted sample except a first send
		push       = accept && !first;
		send_d     = accept && (first || big_change || settle_go);
		settle_d   = push && !big_change && settle_go;
	end

	pwcg_window u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.port         (sel),
		.sample       (w),
		.push         (fire && push),
		.settle_range (cfg.settle_range),
		.settled      (win_settled)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int p = 0; p < NUM_PORTS; p++) begin
				last_width_q[p] <= '0;
				last_time_q[p]  <= '0;
				settled_q[p]    <= 1'b0;
			end
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (advance) valid_s2 <= valid_s1;
			if (fire && accept) begin
				// a change send or first send re-arms settling, a settle send disarms it
				if (first || big_change) settled_q[sel] <= 1'b0;
				else if (settle_go) settled_q[sel] <= 1'b1;
				if (send_d) begin
					last_width_q[sel] <= w;
					last_time_q[sel]  <= now_ms_s1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			port_index_s1  <= port_index;
			pulse_width_s1 <= pulse_width;
			now_ms_s1      <= now_ms;
		end
		if (fire) begin
			send_s2       <= send_d;
			sent_width_s2 <= send_d ? w : '0;
			sent_port_s2  <= port_index_s1;
			settle_s2     <= settle_d;
		end
	end

	assign out_valid   = valid_s2;
	assign send        = send_s2;
	assign sent_width  = sent_width_s2;
	assign sent_port   = sent_port_s2;
	assign settle_send = settle_s2;

endmodule

// File: rtl/pwcg_checker.sv
// port-level checks on the pulse width change gate result channel
// depends on pulse_width_change_gate_assert.svh; bound to pulse_width_change_gate
`include "pulse_width_change_gate_assert.svh"

module pwcg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        send,
	input logic [11:0] sent_width,
	input logic        settle_send
);

	// a held result stays and keeps its width
	`PWCG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`PWCG_ASSERT_NEXT(a_width_hold, clk, arst_n, out_valid && out_stall, $stable(sent_width))

	// a settle send is always a send
	`PWCG_ASSERT_IMPLY(a_settle_is_send, clk, arst_n, out_valid && settle_send, send)

	// a dropped pulse carries no width
	`PWCG_ASSERT_IMPLY(a_drop_no_width, clk, arst_n, out_valid && !send, sent_width == 12'd0)

endmodule

bind pulse_width_change_gate pwcg_checker u_pwcg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.send        (send),
	.sent_width  (sent_width),
	.settle_send (settle_send)
);

// File: bench/pulse_width_change_gate_checker.sv
`timescale 1ns / 100ps
// checker for the pulse width change gate: watches the request, result and
// register channels, predicts each decision and compares it field by field
// depends on pwcg_pkg
module pulse_width_change_gate_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [2:0]                 port_index,
	input  logic [15:0]                pulse_width,
	input  logic [31:0]                now_ms,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic                       send,
	input  logic [11:0]                sent_width,
	input  logic [2:0]                 sent_port,
	input  logic                       settle_send,
	input  logic                       cfg_write,
	input  logic [pwcg_pkg::IDX_W-1:0] cfg_index,
	input  logic [pwcg_pkg::CFG_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         decisions_due
);
	import pwcg_pkg::*;

	typedef struct packed {
		logic        send;
		logic [11:0] width;
		logic [2:0]  port;
		logic        settle;
	} decision_t;

	cfg_t                gate_cfg;
	logic [11:0]         win_samples [NUM_PORTS][WINDOW_LEN];
	int                  win_ptr     [NUM_PORTS];
	logic [11:0]         last_width  [NUM_PORTS];
	logic [31:0]         last_time   [NUM_PORTS];
	logic                settled     [NUM_PORTS];
	decision_t           pending_decisions [$];
	decision_t           oldest;

	function automatic decision_t gate_decide(input logic [2:0] port, input logic [15:0] width,
			input logic [31:0] now);
		decision_t   r;
		logic [11:0] w, prev, change, lo, hi;
		logic [31:0] elapsed;
		logic        stable;
		int          p;
		r = '0;
		r.port = port;
		p = int'(port);
		if (port < NUM_PORTS && ((gate_cfg.port_enable_mask >> port) & 5'd1) != 0 &&
				width >= gate_cfg.pulse_min && width <= gate_cfg.pulse_max) begin
			elapsed = now - last_time[p];
			if (elapsed >= gate_cfg.min_interval_ms) begin
				w = width[11:0];
				prev = last_width[p];
				if (prev == 0) begin
					// nothing sent yet on this port
					r.send = 1'b1;
					settled[p] = 1'b0;
				end else begin
					change = (w > prev) ? w - prev : prev - w;
					win_samples[p][win_ptr[p]] = w;
					win_ptr[p] = (win_ptr[p] == WINDOW_LEN - 1) ? 0 : win_ptr[p] + 1;
					lo = win_samples[p][0];
					hi = win_samples[p][0];
					for (int i = 1; i < WINDOW_LEN; i++) begin
						if (win_samples[p][i] < lo) lo = win_samples[p][i];
						if (win_samples[p][i] > hi) hi = win_samples[p][i];
					end
					stable = (hi - lo) <= gate_cfg.settle_range;
					if (change >= gate_cfg.change_threshold) begin
						r.send = 1'b1;
						settled[p] = 1'b0;
					end else if (stable && !settled[p] && change != 0) begin
						r.send = 1'b1;
						r.settle = 1'b1;
						settled[p] = 1'b1;
					end
				end
				if (r.send) begin
					last_width[p] = w;
					last_time[p] = now;
					r.width = w;
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_cfg = cfg_t'{16'd15, 12'd6, 12'd6, 12'd500, 12'd2500, 5'd0};
			for (int p = 0; p < NUM_PORTS; p++) begin
				for (int i = 0; i < WINDOW_LEN; i++) win_samples[p][i] = '0;
				win_ptr[p] = 0;
				last_width[p] = '0;
				last_time[p] = '0;
				settled[p] = 1'b0;
			end
			pending_decisions.delete();
			fail_count = 0;
			decisions_due <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_decisions.size() == 0) begin
					$display("%0t: unexpected result send %0b width %0d port %0d settle %0b",
						$time, send, sent_width, sent_port, settle_send);
					fail_count++;
				end else begin
					oldest = pending_decisions.pop_front();
					if (send !== oldest.send) begin
						$display("%0t: send expected %0b got %0b", $time, oldest.send, send);
						fail_count++;
					end
					if (sent_width !== oldest.width) begin
						$display("%0t: sent_width expected %0d got %0d",
							$time, oldest.width, sent_width);
						fail_count++;
					end
					if (sent_port !== oldest.port) begin
						$display("%0t: sent_port expected %0d got %0d",
							$time, oldest.port, sent_port);
						fail_count++;
					end
					if (settle_send !== oldest.settle) begin
						$display("%0t: settle_send expected %0b got %0b",
							$time, oldest.settle, settle_send);
						fail_count++;
					end
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_MIN_INTERVAL: gate_cfg.min_interval_ms = cfg_data[15:0];
					REG_CHANGE_THR:   gate_cfg.change_threshold = cfg_data[11:0];
					REG_SETTLE_RANGE: gate_cfg.settle_range = cfg_data[11:0];
					REG_PULSE_MIN:    gate_cfg.pulse_min = cfg_data[11:0];
					REG_PULSE_MAX:    gate_cfg.pulse_max = cfg_data[11:0];
					REG_PORT_ENABLE:  gate_cfg.port_enable_mask = cfg_data[4:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				pending_decisions.push_back(gate_decide(port_index, pulse_width, now_ms));
			decisions_due <= pending_decisions.size();
		end
	end

endmodule

// File: bench/pulse_width_change_gate_tb.sv
`timescale 1ns / 100ps
// top of the pulse width change gate bench: clock, reset, register writes,
// request stimulus and result stall, verdict
// depends on pwcg_pkg, pulse_width_change_gate and pulse_width_change_gate_checker
module pulse_width_change_gate_tb;
	import pwcg_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [2:0]        port_index = '0;
	logic [15:0]       pulse_width = '0;
	logic [31:0]       now_ms = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              send;
	logic [11:0]       sent_width;
	logic [2:0]        sent_port;
	logic              settle_send;
	logic              cfg_write = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;
	int                fail_count;
	int                decisions_due;

	// idling controls shared between the request side and the result side
	bit quiet_send = 1'b0;
	bit quiet_recv = 1'b0;
	bit hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pulse_width_change_gate DUT (.*);

	pulse_width_change_gate_checker checker_i (.*);

	// one register write per edge; cfg_write stays high across back-to-back writes
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// only called while the gate is idle: after reset or after a drain
	task automatic set_config(input cfg_t c);
		write_reg(REG_MIN_INTERVAL, c.min_interval_ms);
		write_reg(REG_CHANGE_THR, CFG_W'(c.change_threshold));
		write_reg(REG_SETTLE_RANGE, CFG_W'(c.settle_range));
		write_reg(REG_PULSE_MIN, CFG_W'(c.pulse_min));
		write_reg(REG_PULSE_MAX, CFG_W'(c.pulse_max));
		write_reg(REG_PORT_ENABLE, CFG_W'(c.port_enable_mask));
		cfg_write <= 1'b0;
	endtask

	// offer one request after a random gap and hold it until taken;
	// with no gap the valid simply stays high into the next request
	task automatic send_request(input logic [2:0] port, input logic [15:0] width,
			input logic [31:0] now);
		int gap;
		gap = quiet_send ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		port_index <= port;
		pulse_width <= width;
		now_ms <= now;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// every request yields exactly one result, so an empty checker queue means idle;
	// sampled on the falling edge to stay clear of the checker's update
	task automatic wait_drained;
		in_valid <= 1'b0;
		do @(negedge clk); while (decisions_due != 0);
		@(posedge clk);
	endtask

	// random phase: mostly per-port runs around a slowly moving target so that
	// windows fill and settle, plus boundary widths and raw noise
	task automatic run_random(input cfg_t c, input int count, input bit with_pressure);
		int          kind;
		int          target [NUM_PORTS];
		logic [31:0] clock_ms;
		logic [2:0]  port;
		logic [15:0] width;
		clock_ms = $urandom();
		for (int p = 0; p < NUM_PORTS; p++)
			target[p] = $urandom_range(c.pulse_min, c.pulse_max);
		set_config(c);
		for (int i = 0; i < count; i++) begin
			// switch idling style every fifty requests, some stretches with none at all
			if (i % 50 == 0) begin
				quiet_send = ($urandom_range(0, 3) == 0);
				quiet_recv = ($urandom_range(0, 3) == 0);
			end
			// long receiver hold while requests keep coming back to back
			if (with_pressure && i == count / 2) begin
				hold_req = 1'b1;
				quiet_send = 1'b1;
			end
			kind = $urandom_range(0, 99);
			clock_ms += $urandom_range(0, c.min_interval_ms / 2 + 4);
			if (kind < 2)
				clock_ms = $urandom();
			if (kind < 10) begin
				port = 3'($urandom_range(0, 7));
				width = 16'($urandom());
			end else begin
				port = 3'($urandom_range(0, NUM_PORTS - 1));
				if ($urandom_range(0, 19) == 0)
					target[port] = $urandom_range(c.pulse_min, c.pulse_max);
				if (kind < 12)
					width = 16'(c.pulse_min) - 16'd1 + 16'($urandom_range(0, 2));
				else if (kind < 14)
					width = 16'(c.pulse_max) - 16'd1 + 16'($urandom_range(0, 2));
				else
					width = 16'(target[port] + $urandom_range(0, 3));
			end
			send_request(port, width, clock_ms);
		end
		quiet_send = 1'b0;
		wait_drained();
	endtask

	// result side: random stall per result, or a long hold when asked
	initial begin
		int hold;
		forever begin
			if (hold_req) begin
				hold = 64;
				hold_req = 1'b0;
			end else begin
				hold = quiet_recv ? 0 : $urandom_range(0, 8);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: every port disabled, so nothing goes through
		send_request(3'd0, 16'd1500, 32'd100);
		send_request(3'd7, 16'd1500, 32'd100);
		wait_drained();

		set_config(cfg_t'{16'd15, 12'd6, 12'd6, 12'd500, 12'd2500, 5'h1f});
		// too early after reset, then first send, then inside the interval
		send_request(3'd0, 16'd1500, 32'd5);
		send_request(3'd0, 16'd1500, 32'd20);
		send_request(3'd0, 16'd1510, 32'd25);
		// small change only: window fills, settles on the fifth sample and sends once
		send_request(3'd0, 16'd1503, 32'd40);
		send_request(3'd0, 16'd1503, 32'd60);
		send_request(3'd0, 16'd1503, 32'd80);
		send_request(3'd0, 16'd1503, 32'd100);
		send_request(3'd0, 16'd1503, 32'd120);
		send_request(3'd0, 16'd1503, 32'd140);
		// already settled, small change is held back; a large change goes out
		send_request(3'd0, 16'd1504, 32'd160);
		send_request(3'd0, 16'd1520, 32'd180);
		// width bounds on their edges and beyond
		send_request(3'd1, 16'd499, 32'd200);
		send_request(3'd1, 16'd500, 32'd200);
		send_request(3'd1, 16'd2500, 32'd300);
		send_request(3'd1, 16'd2501, 32'd400);
		send_request(3'd1, 16'hffff, 32'd500);
		// ports past the last one
		send_request(3'd5, 16'd1500, 32'd600);
		send_request(3'd6, 16'd1500, 32'd600);
		// time wrapping through zero
		send_request(3'd2, 16'd1000, 32'hffff_fff0);
		send_request(3'd2, 16'd1100, 32'h0000_0005);
		wait_drained();

		// zero width accepted and sent, so the next one counts as a first send;
		// zero threshold makes even an unchanged value go out
		set_config(cfg_t'{16'd0, 12'd0, 12'd0, 12'd0, 12'd4095, 5'h1f});
		send_request(3'd3, 16'd0, 32'd1000);
		send_request(3'd3, 16'd4095, 32'd1000);
		send_request(3'd3, 16'd4095, 32'd1000);
		wait_drained();

		// empty width range rejects everything
		set_config(cfg_t'{16'd15, 12'd6, 12'd6, 12'd4095, 12'd0, 5'h1f});
		send_request(3'd4, 16'd2000, 32'd5000);
		send_request(3'd4, 16'd4095, 32'd5000);
		wait_drained();

		run_random(cfg_t'{16'd15, 12'd6, 12'd6, 12'd500, 12'd2500, 5'h1f}, 250, 1'b1);
		run_random(cfg_t'{16'd0, 12'd0, 12'd0, 12'd0, 12'd4095, 5'b10101}, 250, 1'b0);
		run_random(cfg_t'{16'hffff, 12'd4095, 12'd4095, 12'd1000, 12'd2000, 5'h1f}, 250, 1'b0);
		run_random(cfg_t'{16'd40, 12'd20, 12'd10, 12'd800, 12'd2200, 5'b01110}, 250, 1'b0);
		run_random(cfg_t'{16'd1, 12'd3, 12'd2, 12'd0, 12'd4095, 5'h1f}, 250, 1'b1);
		run_random(cfg_t'{16'd15, 12'd6, 12'd6, 12'd500, 12'd2500, 5'h1f}, 250, 1'b0);

		// let any stray result show up before the verdict
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#3_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
